FILE: src/vmix_pkg.sv
// Shared types and constants for the priority voice PCM mixer.
// Depends on nothing; used by the mixer core.
package vmix_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD     = 3'd0,
    MODE_START    = 3'd1,
    MODE_STOP     = 3'd2,
    MODE_STOP_ALL = 3'd3,
    MODE_LEVELS   = 3'd4,
    MODE_LOOP     = 3'd5,
    MODE_OWNED    = 3'd6,
    MODE_MIX      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_STARTED = 2'd1,
    KIND_REFUSED = 2'd2,
    KIND_NOTICE  = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START_SCAN,
    S_EVICT,
    S_SETUP,
    S_REFUSE,
    S_FIND,
    S_STOP_ALL,
    S_FLUSH,
    S_MIX_CHK,
    S_MIX_MOD,
    S_MIX_FETCH,
    S_MIX_DATA,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_MUL4,
    S_ACC,
    S_MIX_NOTE,
    S_MIX_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [16:0] sample_length;
    logic [9:0]  sound_id;
    logic [7:0]  priority_req;
    logic [7:0]  left_level;
    logic [7:0]  right_level;
    logic [39:0] step;
    logic [15:0] handle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [15:0]        voice_handle;
    logic [9:0]         finished_sound;
    logic               last;
  } out_word_t;

  localparam logic [7:0]  MASTER_RESET = 8'd220;
  localparam logic [7:0]  SAMPLE_ZERO  = 8'd128;
  localparam int unsigned LEVEL_DIV    = 65025;
  // floor(2^40 / 65025): q = (p * 256) / 65025 ~ (p * DIV_RECIP) >> 32, low by at most one
  localparam logic [24:0] DIV_RECIP    = 25'((64'd1 << 40) / 64'd65025);
  localparam int          SAT_MAX      = 32767;
  localparam int          SAT_MIN      = -32768;

endpackage

FILE: src/vmix_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the mixer's sample bytes.
module vmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/priority_voice_pcm_mixer_core.sv
// Priority voice PCM mixer top level: voice table, sequencer and shared multiplier.
// Depends on vmix_pkg and vmix_ram.
//
// Usage: one input word per command on in_word (in_valid/in_stall). The block
// takes a word only when idle and raises in_stall until it has finished it.
// Results leave on out_word (out_valid/out_stall) through one output register;
// a stalled result holds and the sequencer waits at its next result.
// Load writes one sample byte and stays idle. Start walks the voice table, one
// voice per cycle. Stop, levels, loop and owned walk the table up to the
// addressed voice. Mix takes the word, then per voice skips it if idle,
// clears it if it ends (with a notice if owned), and if it plays fetches a
// sample and runs four multiplier passes and an accumulate per channel on the
// one shared multiplier; a looping voice that wraps first reduces its index
// modulo its length, one remainder bit a cycle. Last comes the frame.
// cfg_we writes master level at once; write it only while the block is idle.
// Reset idles every voice, sets the next handle to 1 and master level to 220;
// the sample memory is not cleared and must be loaded before it is played.
module priority_voice_pcm_mixer_core #(
  parameter int VOICE_COUNT      = 16,
  parameter int SAMPLE_ADDR_BITS = 16,
  parameter int HANDLE_BITS      = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vmix_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output vmix_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import vmix_pkg::*;

  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int AW    = SAMPLE_ADDR_BITS;
  localparam int HW    = HANDLE_BITS;
  localparam int ACC_W = 18 + $clog2(VOICE_COUNT);

  // voice table
  logic [VOICE_COUNT-1:0] act_r;
  logic [HW-1:0]  hnd_r   [VOICE_COUNT];
  logic [9:0]     snd_r   [VOICE_COUNT];
  logic [7:0]     prio_r  [VOICE_COUNT];
  logic           loop_r  [VOICE_COUNT];
  logic           own_r   [VOICE_COUNT];
  logic [7:0]     lev_l_r [VOICE_COUNT];
  logic [7:0]     lev_r_r [VOICE_COUNT];
  logic [AW-1:0]  base_r  [VOICE_COUNT];
  logic [16:0]    len_r   [VOICE_COUNT];
  logic [63:0]    pos_r   [VOICE_COUNT];
  logic [39:0]    step_r  [VOICE_COUNT];

  state_t state_r, state_nxt;
  in_word_t item_r, item_nxt;
  logic [VW-1:0] vidx_r, vidx_nxt;
  logic cand_valid_r, cand_valid_nxt;
  logic [VW-1:0] cand_idx_r, cand_idx_nxt;
  logic [7:0] cand_prio_r, cand_prio_nxt;
  logic cand_loop_r, cand_loop_nxt;
  logic pend_valid_r, pend_valid_nxt;
  logic [9:0] pend_snd_r, pend_snd_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt;
  logic ch_r, ch_nxt;
  logic [48:0] mul_p_r;
  logic [23:0] p2_r, p2_nxt;
  logic [15:0] q0_r, q0_nxt;
  logic signed [ACC_W-1:0] acc_l_r, acc_l_nxt, acc_r_r, acc_r_nxt;
  logic [HW-1:0] next_handle_r, next_handle_nxt;
  logic [7:0] master_r;
  logic out_valid_r;
  out_word_t out_word_r;

  // strobes into the voice table at vidx_r
  logic act_clr, setup_we, lev_we, loop_we, own_we, pos_we;
  logic [63:0] pos_wdata;
  logic [23:0] mul_a;
  logic [24:0] mul_b;
  logic emit_en;
  out_word_t emit_word;

  logic in_acc, out_free, last_v;
  logic cur_act, cur_loop, cur_own, match, beats_cand, over, ends, stopall_hold;
  logic [7:0] cur_prio;
  logic [16:0] cur_len;
  logic [31:0] cur_idx;
  logic [17:0] mod_shift;
  logic [17:0] mod_diff;
  logic [16:0] mod_next;
  logic [7:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic [31:0] div_rem;
  logic [15:0] q_fix;
  logic signed [ACC_W-1:0] term;
  logic signed [15:0] sat_l, sat_r;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_v    = (vidx_r == VW'(VOICE_COUNT - 1));

  assign cur_act  = act_r[vidx_r];
  assign cur_loop = loop_r[vidx_r];
  assign cur_own  = own_r[vidx_r];
  assign cur_prio = prio_r[vidx_r];
  assign cur_len  = len_r[vidx_r];
  assign cur_idx  = pos_r[vidx_r][63:32];
  assign match    = cur_act && (32'(hnd_r[vidx_r]) == 32'(item_r.handle));
  assign beats_cand = (cur_prio <= item_r.priority_req) &&
                      (!cand_valid_r || (cur_prio < cand_prio_r) ||
                       (cand_loop_r && !cur_loop));
  assign over  = (cur_idx >= 32'(cur_len));
  assign ends  = !cur_loop || (cur_len == 17'd0);
  assign stopall_hold = cur_act && cur_own && pend_valid_r && !out_free;

  // one remainder bit of idx mod len per cycle, MSB first
  assign mod_shift = {rem_r, cur_idx[5'd31 - bit_cnt_r]};
  assign mod_diff  = mod_shift - {1'b0, cur_len};
  assign mod_next  = (mod_shift >= {1'b0, cur_len}) ? mod_diff[16:0] : mod_shift[16:0];

  assign rd_addr = base_r[vidx_r] + AW'(cur_idx);

  // correct the reciprocal estimate by one compare and add
  assign div_rem = {p2_r, 8'd0} - mul_p_r[31:0];
  assign q_fix   = q0_r + ((div_rem >= 32'(LEVEL_DIV)) ? 16'd1 : 16'd0);
  assign term    = neg_r ? -ACC_W'($signed({1'b0, q_fix})) : ACC_W'($signed({1'b0, q_fix}));

  always_comb begin
    if (acc_l_r > ACC_W'(SAT_MAX)) begin
      sat_l = 16'sh7fff;
    end else if (acc_l_r < ACC_W'(SAT_MIN)) begin
      sat_l = 16'sh8000;
    end else begin
      sat_l = 16'(acc_l_r);
    end
    if (acc_r_r > ACC_W'(SAT_MAX)) begin
      sat_r = 16'sh7fff;
    end else if (acc_r_r < ACC_W'(SAT_MIN)) begin
      sat_r = 16'sh8000;
    end else begin
      sat_r = 16'(acc_r_r);
    end
  end

  vmix_ram #(
    .WIDTH(8),
    .DEPTH(1 << SAMPLE_ADDR_BITS)
  ) u_sample_ram (
    .clk    (clk),
    .wr_en  (in_acc && (mode_t'(in_word.mode) == MODE_LOAD)),
    .wr_addr(AW'(in_word.address)),
    .wr_data(in_word.data_byte),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_t'(in_word.mode))
            MODE_LOAD:     state_nxt = S_IDLE;
            MODE_START:    state_nxt = S_START_SCAN;
            MODE_STOP_ALL: state_nxt = S_STOP_ALL;
            MODE_MIX:      state_nxt = S_MIX_CHK;
            default:       state_nxt = S_FIND;
          endcase
        end
      end
      S_START_SCAN: begin
        if (!cur_act) begin
          state_nxt = S_SETUP;
        end else if (last_v) begin
          state_nxt = (cand_valid_r || beats_cand) ? S_EVICT : S_REFUSE;
        end
      end
      S_EVICT: begin
        if (!cur_own || out_free) state_nxt = S_SETUP;
      end
      S_SETUP, S_REFUSE, S_FLUSH, S_MIX_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_FIND: begin
        if (match || last_v) state_nxt = S_IDLE;
      end
      S_STOP_ALL: begin
        if (!stopall_hold && last_v) begin
          state_nxt = (pend_valid_r || (cur_act && cur_own)) ? S_FLUSH : S_IDLE;
        end
      end
      S_MIX_CHK: begin
        if (!cur_act) begin
          state_nxt = last_v ? S_MIX_OUT : S_MIX_CHK;
        end else if (over) begin
          if (!ends) begin
            state_nxt = S_MIX_MOD;
          end else if (cur_own) begin
            state_nxt = S_MIX_NOTE;
          end else begin
            state_nxt = last_v ? S_MIX_OUT : S_MIX_CHK;
          end
        end else begin
          state_nxt = S_MIX_FETCH;
        end
      end
      S_MIX_MOD: begin
        if (bit_cnt_r == 5'd31) state_nxt = S_MIX_FETCH;
      end
      S_MIX_FETCH: state_nxt = S_MIX_DATA;
      S_MIX_DATA:  state_nxt = S_MUL1;
      S_MUL1:      state_nxt = S_MUL2;
      S_MUL2:      state_nxt = S_MUL3;
      S_MUL3:      state_nxt = S_MUL4;
      S_MUL4:      state_nxt = S_ACC;
      S_ACC: begin
        if (!ch_r) begin
          state_nxt = S_MUL1;
        end else begin
          state_nxt = last_v ? S_MIX_OUT : S_MIX_CHK;
        end
      end
      S_MIX_NOTE: begin
        if (out_free) state_nxt = last_v ? S_MIX_OUT : S_MIX_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    item_nxt        = item_r;
    vidx_nxt        = vidx_r;
    cand_valid_nxt  = cand_valid_r;
    cand_idx_nxt    = cand_idx_r;
    cand_prio_nxt   = cand_prio_r;
    cand_loop_nxt   = cand_loop_r;
    pend_valid_nxt  = pend_valid_r;
    pend_snd_nxt    = pend_snd_r;
    rem_nxt         = rem_r;
    bit_cnt_nxt     = bit_cnt_r;
    mag_nxt         = mag_r;
    neg_nxt         = neg_r;
    ch_nxt          = ch_r;
    p2_nxt          = p2_r;
    q0_nxt          = q0_r;
    acc_l_nxt       = acc_l_r;
    acc_r_nxt       = acc_r_r;
    next_handle_nxt = next_handle_r;
    act_clr   = 1'b0;
    setup_we  = 1'b0;
    lev_we    = 1'b0;
    loop_we   = 1'b0;
    own_we    = 1'b0;
    pos_we    = 1'b0;
    pos_wdata = pos_r[vidx_r] + 64'(step_r[vidx_r]);
    mul_a     = 24'd0;
    mul_b     = 25'd0;
    emit_en   = 1'b0;
    emit_word = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt       = in_word;
          vidx_nxt       = '0;
          cand_valid_nxt = 1'b0;
          pend_valid_nxt = 1'b0;
          acc_l_nxt      = '0;
          acc_r_nxt      = '0;
        end
      end
      S_START_SCAN: begin
        if (cur_act) begin
          if (beats_cand) begin
            cand_valid_nxt = 1'b1;
            cand_idx_nxt   = vidx_r;
            cand_prio_nxt  = cur_prio;
            cand_loop_nxt  = cur_loop;
          end
          if (last_v) begin
            // move to the eviction candidate
            vidx_nxt = beats_cand ? vidx_r : cand_idx_r;
          end else begin
            vidx_nxt = vidx_r + VW'(1);
          end
        end
      end
      S_EVICT: begin
        if (cur_own && out_free) begin
          emit_en                  = 1'b1;
          emit_word.kind           = KIND_NOTICE;
          emit_word.finished_sound = snd_r[vidx_r];
        end
      end
      S_SETUP: begin
        if (out_free) begin
          setup_we               = 1'b1;
          emit_en                = 1'b1;
          emit_word.kind         = KIND_STARTED;
          emit_word.voice_handle = 16'(next_handle_r);
          emit_word.last         = 1'b1;
          next_handle_nxt        = next_handle_r + HW'(1);
          if (next_handle_nxt == '0) next_handle_nxt = HW'(1);
        end
      end
      S_REFUSE: begin
        if (out_free) begin
          emit_en        = 1'b1;
          emit_word.kind = KIND_REFUSED;
          emit_word.last = 1'b1;
        end
      end
      S_FIND: begin
        if (match) begin
          case (mode_t'(item_r.mode))
            MODE_STOP:   act_clr = 1'b1;
            MODE_LEVELS: lev_we  = 1'b1;
            MODE_LOOP:   loop_we = 1'b1;
            MODE_OWNED:  own_we  = 1'b1;
            default:     act_clr = 1'b0;
          endcase
        end else if (!last_v) begin
          vidx_nxt = vidx_r + VW'(1);
        end
      end
      S_STOP_ALL: begin
        // hold one notice back so the final one can carry last
        if (!stopall_hold) begin
          if (cur_act) begin
            act_clr = 1'b1;
            if (cur_own) begin
              if (pend_valid_r) begin
                emit_en                  = 1'b1;
                emit_word.kind           = KIND_NOTICE;
                emit_word.finished_sound = pend_snd_r;
              end
              pend_valid_nxt = 1'b1;
              pend_snd_nxt   = snd_r[vidx_r];
            end
          end
          if (!last_v) vidx_nxt = vidx_r + VW'(1);
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit_en                  = 1'b1;
          emit_word.kind           = KIND_NOTICE;
          emit_word.finished_sound = pend_snd_r;
          emit_word.last           = 1'b1;
        end
      end
      S_MIX_CHK: begin
        if (!cur_act) begin
          if (!last_v) vidx_nxt = vidx_r + VW'(1);
        end else if (over) begin
          if (ends) begin
            act_clr = 1'b1;
            if (!cur_own && !last_v) vidx_nxt = vidx_r + VW'(1);
          end else begin
            rem_nxt     = '0;
            bit_cnt_nxt = '0;
          end
        end
      end
      S_MIX_MOD: begin
        rem_nxt     = mod_next;
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'd31) begin
          pos_we    = 1'b1;
          pos_wdata = {15'd0, mod_next, pos_r[vidx_r][31:0]};
        end
      end
      S_MIX_DATA: begin
        neg_nxt = (rd_data < SAMPLE_ZERO);
        mag_nxt = (rd_data < SAMPLE_ZERO) ? (SAMPLE_ZERO - rd_data) : (rd_data - SAMPLE_ZERO);
        ch_nxt  = 1'b0;
      end
      S_MUL1: begin
        mul_a = 24'(mag_r);
        mul_b = 25'(ch_r ? lev_r_r[vidx_r] : lev_l_r[vidx_r]);
      end
      S_MUL2: begin
        mul_a = 24'(mul_p_r[15:0]);
        mul_b = 25'(master_r);
      end
      S_MUL3: begin
        p2_nxt = mul_p_r[23:0];
        mul_a  = mul_p_r[23:0];
        mul_b  = DIV_RECIP;
      end
      S_MUL4: begin
        q0_nxt = mul_p_r[47:32];
        mul_a  = 24'(mul_p_r[47:32]);
        mul_b  = 25'(LEVEL_DIV);
      end
      S_ACC: begin
        if (!ch_r) begin
          acc_l_nxt = acc_l_r + term;
          ch_nxt    = 1'b1;
        end else begin
          acc_r_nxt = acc_r_r + term;
          pos_we    = 1'b1;
          if (!last_v) vidx_nxt = vidx_r + VW'(1);
        end
      end
      S_MIX_NOTE: begin
        if (out_free) begin
          emit_en                  = 1'b1;
          emit_word.kind           = KIND_NOTICE;
          emit_word.finished_sound = snd_r[vidx_r];
          if (!last_v) vidx_nxt = vidx_r + VW'(1);
        end
      end
      S_MIX_OUT: begin
        if (out_free) begin
          emit_en                = 1'b1;
          emit_word.kind         = KIND_FRAME;
          emit_word.left_sample  = sat_l;
          emit_word.right_sample = sat_r;
          emit_word.last         = 1'b1;
        end
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      act_r         <= '0;
      next_handle_r <= HW'(1);
      master_r      <= MASTER_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      next_handle_r <= next_handle_nxt;
      if (cfg_we) master_r <= cfg_wdata;
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (act_clr) act_r[vidx_r] <= 1'b0;
      if (setup_we) act_r[vidx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    vidx_r       <= vidx_nxt;
    cand_valid_r <= cand_valid_nxt;
    cand_idx_r   <= cand_idx_nxt;
    cand_prio_r  <= cand_prio_nxt;
    cand_loop_r  <= cand_loop_nxt;
    pend_valid_r <= pend_valid_nxt;
    pend_snd_r   <= pend_snd_nxt;
    rem_r        <= rem_nxt;
    bit_cnt_r    <= bit_cnt_nxt;
    mag_r        <= mag_nxt;
    neg_r        <= neg_nxt;
    ch_r         <= ch_nxt;
    p2_r         <= p2_nxt;
    q0_r         <= q0_nxt;
    acc_l_r      <= acc_l_nxt;
    acc_r_r      <= acc_r_nxt;
    mul_p_r      <= 49'(mul_a) * 49'(mul_b);
    if (emit_en) out_word_r <= emit_word;
    if (setup_we) begin
      hnd_r[vidx_r]   <= next_handle_r;
      snd_r[vidx_r]   <= item_r.sound_id;
      prio_r[vidx_r]  <= item_r.priority_req;
      loop_r[vidx_r]  <= 1'b0;
      own_r[vidx_r]   <= 1'b0;
      lev_l_r[vidx_r] <= item_r.left_level;
      lev_r_r[vidx_r] <= item_r.right_level;
      base_r[vidx_r]  <= AW'(item_r.address);
      len_r[vidx_r]   <= item_r.sample_length;
      pos_r[vidx_r]   <= '0;
      step_r[vidx_r]  <= (item_r.step == 40'd0) ? 40'd1 : item_r.step;
    end
    if (lev_we) begin
      lev_l_r[vidx_r] <= item_r.left_level;
      lev_r_r[vidx_r] <= item_r.right_level;
    end
    if (loop_we) loop_r[vidx_r] <= 1'b1;
    if (own_we) own_r[vidx_r] <= 1'b1;
    if (pos_we) pos_r[vidx_r] <= pos_wdata;
  end

endmodule
